// ===== rtl/core/sfu_pkg.sv =====
package sfu_pkg;

   // fixed sizes
   localparam int SAMPLE_RATE = 44100;
   localparam int LINE_DEPTH  = 689;
   localparam int AW          = $clog2(LINE_DEPTH);
   localparam int POS_W       = 16 + AW;
   localparam int DIST_W      = POS_W - 15;
   localparam int IDX_W       = AW + 3;
   localparam int SD_W        = 30;
   localparam int SD_FRAC     = 19;
   localparam int TICK_PERIOD = SAMPLE_RATE / 200;
   localparam int TICK_W      = $clog2(TICK_PERIOD + 1);
   localparam int STEP_UNIT   = (256 << SD_FRAC) / SAMPLE_RATE;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 10;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_DRY      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_WET      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_FEEDBACK = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_BASE     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_RESPONSE = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_RATE     = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_DEPTH    = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_SHAPE    = 3'd7;

   // request kinds
   localparam logic REQ_AUDIO = 1'b0;
   localparam logic REQ_PHASE = 1'b1;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ADDR,
      ST_RD0,
      ST_RD1,
      ST_MIX,
      ST_GAIN,
      ST_OUT
   } state_type;

   // per-lane control from the sequencer
   typedef struct packed {
      logic          ld_x;
      logic          ld_a;
      logic          ld_tap;
      logic          ld_gain;
      logic          wr_en;
      logic          clear;
      logic [AW-1:0] rd_addr;
      logic [AW-1:0] wr_addr;
      logic [14:0]   frac;
      logic [8:0]    dry;
      logic [8:0]    wet;
      logic [8:0]    fb;
   } lane_ctl_type;

   typedef logic [7:0] rom_type [256];

   // unsigned long division by shift and subtract, used at elaboration only
   function automatic longint unsigned udiv64(input longint unsigned n,
                                              input longint unsigned d);
      longint unsigned q;
      longint unsigned r;
      q = 0;
      r = 0;
      for (int b = 63; b >= 0; b--) begin
         r = {r[62:0], n[b]};
         if (r >= d) begin
            r = r - d;
            q[b] = 1'b1;
         end
      end
      return q;
   endfunction

   // floor(255*sin(pi*i/256)) by an integer taylor series in q30
   function automatic rom_type build_rom();
      rom_type r;
      longint unsigned x;
      longint unsigned t;
      longint unsigned v;
      longint s;
      int unsigned j;
      for (int i = 0; i < 256; i++) begin
         j = (i <= 128) ? i : 256 - i;
         x = (64'd3373259426 * j) >> 8;
         t = x;
         s = longint'(x);
         for (int k = 1; k < 12; k++) begin
            t = (t * x) >> 30;
            t = (t * x) >> 30;
            t = udiv64(t, longint'((2 * k) * (2 * k + 1)));
            if ((k & 1) == 1) begin
               s = s - longint'(t);
            end else begin
               s = s + longint'(t);
            end
         end
         if (s < 0) begin
            s = 0;
         end
         v = (longint'(s) * 255 + 4096) >> 30;
         r[i] = (v > 255) ? 8'd255 : v[7:0];
      end
      return r;
   endfunction

   localparam rom_type HALF_SINE = build_rom();

   // divide by 256, truncating toward zero
   function automatic logic signed [18:0] div256(input logic signed [26:0] v);
      logic signed [26:0] b;
      b = (v < 0) ? v + 27'sd255 : v;
      return 19'(b >>> 8);
   endfunction

   // clamp to 16 bit signed
   function automatic logic signed [15:0] sat16(input logic signed [19:0] v);
      logic signed [15:0] r;
      if (v > 20'sd32767) begin
         r = 16'sh7fff;
      end else if (v < -20'sd32768) begin
         r = 16'sh8000;
      end else begin
         r = v[15:0];
      end
      return r;
   endfunction

endpackage

// ===== rtl/core/sfu_if.sv =====
interface sfu_req_if;
   logic               valid;
   logic               ready;
   logic               req_type;
   logic signed [15:0] left_in;
   logic signed [15:0] right_in;
   logic [8:0]         phase_value;
   modport source (output valid, req_type, left_in, right_in, phase_value, input ready);
   modport sink (input valid, req_type, left_in, right_in, phase_value, output ready);
endinterface

interface sfu_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] left_out;
   logic signed [15:0] right_out;
   modport source (output valid, left_out, right_out, input ready);
   modport sink (input valid, left_out, right_out, output ready);
endinterface

// ===== rtl/core/sfu_ram.sv =====
module sfu_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 689
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_ff;

   // one write port, registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_ff;
endmodule

// ===== rtl/core/sfu_lane.sv =====
module sfu_lane (
   input  logic                 clock,
   input  sfu_pkg::lane_ctl_type ctl,
   input  logic signed [15:0]   sample,
   output logic signed [15:0]   result
);
   logic signed [15:0] x_ff, x_in;
   logic signed [32:0] prod_a_ff, prod_a_in;
   logic signed [16:0] tap_ff, tap_in;
   logic signed [26:0] wet_p_ff, wet_p_in;
   logic signed [26:0] dry_p_ff, dry_p_in;
   logic signed [26:0] fb_p_ff, fb_p_in;
   logic signed [15:0] y_ff, y_in;
   logic [15:0]        rd_data;
   logic signed [15:0] wb;
   logic signed [33:0] mix_sum;
   logic signed [33:0] mix_bias;
   logic [15:0]        inv_frac;

   sfu_ram #(.WIDTH(16), .DEPTH(sfu_pkg::LINE_DEPTH)) u_line (
      .clock   (clock),
      .wr_en   (ctl.wr_en),
      .wr_addr (ctl.wr_addr),
      .wr_data (ctl.clear ? 16'd0 : wb),
      .rd_addr (ctl.rd_addr),
      .rd_data (rd_data)
   );

   // interpolation between the two taps
   always_comb begin
      inv_frac  = 16'(17'd32768 - {2'b0, ctl.frac});
      prod_a_in = ctl.ld_a ? $signed(rd_data) * $signed({1'b0, inv_frac}) : prod_a_ff;
      mix_sum   = 34'(prod_a_ff) + 34'($signed(rd_data) * $signed({2'b0, ctl.frac}));
      mix_bias  = (mix_sum < 0) ? mix_sum + 34'sd32767 : mix_sum;
      tap_in    = ctl.ld_tap ? 17'(mix_bias >>> 15) : tap_ff;
   end

   // gain products
   always_comb begin
      x_in     = ctl.ld_x ? sample : x_ff;
      wet_p_in = ctl.ld_gain ? 27'(tap_ff * $signed({1'b0, ctl.wet})) : wet_p_ff;
      fb_p_in  = ctl.ld_gain ? 27'(tap_ff * $signed({1'b0, ctl.fb})) : fb_p_ff;
      dry_p_in = ctl.ld_gain ? 27'(x_ff * $signed({1'b0, ctl.dry})) : dry_p_ff;
   end

   // output and write-back sums
   always_comb begin
      wb   = sfu_pkg::sat16(20'(x_ff) + 20'(sfu_pkg::div256(fb_p_ff)));
      y_in = (ctl.wr_en && !ctl.clear)
           ? sfu_pkg::sat16(20'(sfu_pkg::div256(wet_p_ff)) + 20'(sfu_pkg::div256(dry_p_ff)))
           : y_ff;
   end

   always_ff @(posedge clock) begin
      x_ff      <= x_in;
      prod_a_ff <= prod_a_in;
      tap_ff    <= tap_in;
      wet_p_ff  <= wet_p_in;
      dry_p_ff  <= dry_p_in;
      fb_p_ff   <= fb_p_in;
      y_ff      <= y_in;
   end

   assign result = y_ff;
endmodule

// ===== rtl/core/sfu_ctrl.sv =====
module sfu_ctrl (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_type,
   input  logic [8:0]                          phase_value,
   output logic                                req_ready,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   input  logic                                csr_we,
   input  logic [sfu_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [sfu_pkg::CSR_DATA_W-1:0]      csr_wdata,
   output sfu_pkg::lane_ctl_type               ctl
);
   localparam int AW = sfu_pkg::AW;
   localparam int SD_W = sfu_pkg::SD_W;
   localparam int IDX_W = sfu_pkg::IDX_W;

   sfu_pkg::state_type state_ff, state_in;

   // configuration
   logic [8:0] dry_ff, dry_in, wet_ff, wet_in, fb_ff, fb_in;
   logic [9:0] base_ff, base_in;
   logic [8:0] resp_ff, resp_in;
   logic [9:0] rate_ff, rate_in;
   logic [8:0] depth_ff, depth_in;
   logic       shape_ff, shape_in;

   // item state
   logic [SD_W-1:0]           sd_ff, sd_in;
   logic [AW-1:0]             wi_ff, wi_in;
   logic [AW-1:0]             clr_ff, clr_in;
   logic [sfu_pkg::TICK_W-1:0] tick_ff, tick_in;
   logic [11:0]               lfo_ff, lfo_in;
   logic                      rsp_valid_ff, rsp_valid_in;

   // per-item work registers
   logic [sfu_pkg::POS_W-1:0] pos_ff, pos_in;
   logic signed [9:0]         vib_ff, vib_in;
   logic signed [19:0]        vibd_ff, vibd_in;
   logic [SD_W-1:0]           step_ff, step_in;
   logic [AW-1:0]             p2_ff, p2_in, p3_ff, p3_in;
   logic [9:0]                target_ff, target_in;

   logic                      accept, audio, fire, out_free;
   logic [8:0]                lfo_p;
   logic [7:0]                rom_a, rom_b;
   logic [sfu_pkg::DIST_W-1:0] tap_dist;
   logic signed [IDX_W-1:0]   d2, d3;
   logic signed [12:0]        t0, tv;
   logic signed [11:0]        vib_scaled;
   logic signed [19:0]        vibd_bias;
   logic [10:0]               sd_int;
   logic signed [SD_W:0]      sd_dn;
   logic [SD_W:0]             sd_up;
   logic [SD_W-1:0]           sd_snap;
   logic [SD_W-1:0]           sd_slew;

   assign accept   = req_valid && req_ready;
   assign audio    = req_type == sfu_pkg::REQ_AUDIO;
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign fire     = (state_ff == sfu_pkg::ST_OUT) && out_free;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sfu_pkg::ST_CLEAR: begin
            if (clr_ff == AW'(sfu_pkg::LINE_DEPTH - 1)) state_in = sfu_pkg::ST_IDLE;
         end
         sfu_pkg::ST_IDLE: begin
            if (req_valid && audio) state_in = sfu_pkg::ST_ADDR;
         end
         sfu_pkg::ST_ADDR: state_in = sfu_pkg::ST_RD0;
         sfu_pkg::ST_RD0:  state_in = sfu_pkg::ST_RD1;
         sfu_pkg::ST_RD1:  state_in = sfu_pkg::ST_MIX;
         sfu_pkg::ST_MIX:  state_in = sfu_pkg::ST_GAIN;
         sfu_pkg::ST_GAIN: state_in = sfu_pkg::ST_OUT;
         sfu_pkg::ST_OUT: begin
            if (out_free) state_in = sfu_pkg::ST_IDLE;
         end
         default: state_in = sfu_pkg::ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_ready   = state_ff == sfu_pkg::ST_IDLE;
      ctl.ld_x    = accept && audio;
      ctl.ld_a    = state_ff == sfu_pkg::ST_RD1;
      ctl.ld_tap  = state_ff == sfu_pkg::ST_MIX;
      ctl.ld_gain = state_ff == sfu_pkg::ST_GAIN;
      ctl.clear   = state_ff == sfu_pkg::ST_CLEAR;
      ctl.wr_en   = ctl.clear || fire;
      ctl.wr_addr = ctl.clear ? clr_ff : wi_ff;
      ctl.rd_addr = (state_ff == sfu_pkg::ST_RD1) ? p3_ff : p2_ff;
      ctl.frac    = pos_ff[14:0];
      ctl.dry     = dry_ff;
      ctl.wet     = wet_ff;
      ctl.fb      = fb_ff;
   end

   // lfo lookup
   always_comb begin
      lfo_p = lfo_ff[11:3];
      rom_a = sfu_pkg::HALF_SINE[lfo_p[8:1]];
      rom_b = sfu_pkg::HALF_SINE[lfo_p[7:0]];
      if (shape_ff == 1'b0) begin
         vib_in = $signed({1'b0, rom_a, 1'b0}) - 10'sd256;
      end else if (lfo_p[8]) begin
         vib_in = -$signed({2'b0, rom_b});
      end else begin
         vib_in = $signed({2'b0, rom_b});
      end
      if (!(accept && audio)) vib_in = vib_ff;
   end

   // tap addresses
   always_comb begin
      tap_dist = pos_ff[sfu_pkg::POS_W-1:15];
      d2    = $signed(IDX_W'(wi_ff)) - $signed(IDX_W'(tap_dist));
      d3    = d2 - IDX_W'(1);
      if (d2 < 0) d2 = d2 + IDX_W'(sfu_pkg::LINE_DEPTH);
      if (d3 < 0) d3 = d3 + IDX_W'(sfu_pkg::LINE_DEPTH);
      if (d2 < 0 || d2 >= IDX_W'(sfu_pkg::LINE_DEPTH)) d2 = '0;
      if (d3 < 0 || d3 >= IDX_W'(sfu_pkg::LINE_DEPTH)) d3 = '0;
      p2_in   = (state_ff == sfu_pkg::ST_ADDR) ? d2[AW-1:0] : p2_ff;
      p3_in   = (state_ff == sfu_pkg::ST_ADDR) ? d3[AW-1:0] : p3_ff;
      pos_in  = (accept && audio)
              ? sfu_pkg::POS_W'(sd_ff[SD_W-1:14] * sfu_pkg::POS_W'(sfu_pkg::LINE_DEPTH))
              : pos_ff;
      vibd_in = (state_ff == sfu_pkg::ST_ADDR)
              ? 20'(vib_ff * $signed({1'b0, depth_ff})) : vibd_ff;
      step_in = (state_ff == sfu_pkg::ST_ADDR)
              ? SD_W'(SD_W'(resp_ff) * SD_W'(4 * sfu_pkg::STEP_UNIT)) : step_ff;
   end

   // target delay: clamp base, add scaled lfo
   always_comb begin
      vibd_bias  = (vibd_ff < 0) ? vibd_ff + 20'sd255 : vibd_ff;
      vib_scaled = 12'(vibd_bias >>> 8);
      t0 = $signed({3'b0, base_ff});
      if (t0 - $signed({4'b0, depth_ff}) < 13'sd8) t0 = 13'sd8 + $signed({4'b0, depth_ff});
      if (t0 + $signed({4'b0, depth_ff}) > 13'sd1000) t0 = 13'sd1000 - $signed({4'b0, depth_ff});
      tv = t0 + 13'(vib_scaled);
      if (tv < 0) tv = '0;
      target_in = (state_ff == sfu_pkg::ST_RD0) ? tv[9:0] : target_ff;
   end

   // slew of the smoothed delay
   always_comb begin
      sd_int  = sd_ff[SD_W-1:sfu_pkg::SD_FRAC];
      sd_snap = SD_W'({target_ff, 19'd0});
      sd_dn   = $signed({1'b0, sd_ff}) - $signed({1'b0, step_ff});
      sd_up   = {1'b0, sd_ff} + {1'b0, step_ff};
      sd_slew = sd_ff;
      if (sd_int > 11'(target_ff)) begin
         if (sd_dn < 0 || sd_dn[SD_W-1:sfu_pkg::SD_FRAC] < 11'(target_ff)) begin
            sd_slew = sd_snap;
         end else begin
            sd_slew = sd_dn[SD_W-1:0];
         end
      end else if (sd_int < 11'(target_ff)) begin
         if (sd_up[SD_W:sfu_pkg::SD_FRAC] > 12'(target_ff)) begin
            sd_slew = sd_snap;
         end else begin
            sd_slew = sd_up[SD_W-1:0];
         end
      end
   end

   // configuration writes and per-item state
   always_comb begin
      dry_in   = dry_ff;
      wet_in   = wet_ff;
      fb_in    = fb_ff;
      base_in  = base_ff;
      resp_in  = resp_ff;
      rate_in  = rate_ff;
      depth_in = depth_ff;
      shape_in = shape_ff;
      sd_in    = fire ? sd_slew : sd_ff;
      if (csr_we) begin
         unique case (csr_index)
            sfu_pkg::REG_DRY:      dry_in   = csr_wdata[8:0];
            sfu_pkg::REG_WET:      wet_in   = csr_wdata[8:0];
            sfu_pkg::REG_FEEDBACK: fb_in    = csr_wdata[8:0];
            sfu_pkg::REG_BASE: begin
               base_in = csr_wdata;
               sd_in   = SD_W'({csr_wdata, 19'd0});
            end
            sfu_pkg::REG_RESPONSE: resp_in  = csr_wdata[8:0];
            sfu_pkg::REG_RATE:     rate_in  = csr_wdata;
            sfu_pkg::REG_DEPTH:    depth_in = csr_wdata[8:0];
            sfu_pkg::REG_SHAPE:    shape_in = csr_wdata[0];
            default: ;
         endcase
      end
      clr_in = (state_ff == sfu_pkg::ST_CLEAR) ? clr_ff + AW'(1) : clr_ff;
      wi_in  = wi_ff;
      tick_in = tick_ff;
      lfo_in  = lfo_ff;
      if (accept && !audio) begin
         lfo_in = {phase_value[7:0], 4'b0};
      end
      if (fire) begin
         wi_in = (wi_ff == AW'(sfu_pkg::LINE_DEPTH - 1)) ? '0 : wi_ff + AW'(1);
         if (tick_ff + sfu_pkg::TICK_W'(1) >= sfu_pkg::TICK_W'(sfu_pkg::TICK_PERIOD)) begin
            tick_in = '0;
            lfo_in  = lfo_ff + 12'(rate_ff);
         end else begin
            tick_in = tick_ff + sfu_pkg::TICK_W'(1);
         end
      end
      rsp_valid_in = fire || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sfu_pkg::ST_CLEAR;
         dry_ff       <= 9'd256;
         wet_ff       <= 9'd128;
         fb_ff        <= 9'd128;
         base_ff      <= 10'd200;
         resp_ff      <= 9'd2;
         rate_ff      <= 10'd8;
         depth_ff     <= 9'd32;
         shape_ff     <= 1'b0;
         sd_ff        <= SD_W'({10'd200, 19'd0});
         wi_ff        <= '0;
         clr_ff       <= '0;
         tick_ff      <= '0;
         lfo_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         dry_ff       <= dry_in;
         wet_ff       <= wet_in;
         fb_ff        <= fb_in;
         base_ff      <= base_in;
         resp_ff      <= resp_in;
         rate_ff      <= rate_in;
         depth_ff     <= depth_in;
         shape_ff     <= shape_in;
         sd_ff        <= sd_in;
         wi_ff        <= wi_in;
         clr_ff       <= clr_in;
         tick_ff      <= tick_in;
         lfo_ff       <= lfo_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // work registers
   always_ff @(posedge clock) begin
      pos_ff    <= pos_in;
      vib_ff    <= vib_in;
      vibd_ff   <= vibd_in;
      step_ff   <= step_in;
      p2_ff     <= p2_in;
      p3_ff     <= p3_in;
      target_ff <= target_in;
   end

   assign rsp_valid = rsp_valid_ff;
endmodule

// ===== rtl/core/stereo_flanger_unit.sv =====
// Stereo flanger: an audio request (req_type 0) steps through the address,
// two read, mix, gain and output states, and reaches the result register as
// it leaves the output state, which waits while an earlier result is held;
// the next request is accepted only after that, one request at a time; the
// sequencer reads the two interpolation taps one after the other through the
// single read port of each channel's delay-line memory. A set-phase request
// gives no result. A new request is taken once the previous one has reached
// the output register, even while that result still waits. After reset the
// block zeroes both delay lines before it takes a request; register writes
// are accepted at any time but must only be made while idle.
module stereo_flanger_unit (
   input  logic                           clock,
   input  logic                           reset,
   sfu_req_if.sink                        req_if,
   sfu_rsp_if.source                      rsp_if,
   input  logic                           csr_we,
   input  logic [sfu_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [sfu_pkg::CSR_DATA_W-1:0] csr_wdata
);
   sfu_pkg::lane_ctl_type ctl;
   logic signed [15:0]    left_y, right_y;

   sfu_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_if.valid),
      .req_type    (req_if.req_type),
      .phase_value (req_if.phase_value),
      .req_ready   (req_if.ready),
      .rsp_valid   (rsp_if.valid),
      .rsp_ready   (rsp_if.ready),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .ctl         (ctl)
   );

   // one lane per channel
   sfu_lane u_left (
      .clock  (clock),
      .ctl    (ctl),
      .sample (req_if.left_in),
      .result (left_y)
   );

   sfu_lane u_right (
      .clock  (clock),
      .ctl    (ctl),
      .sample (req_if.right_in),
      .result (right_y)
   );

   // merge the lanes into one stereo frame
   assign rsp_if.left_out  = left_y;
   assign rsp_if.right_out = right_y;
endmodule

// ===== sim/stereo_flanger_unit_tb.sv =====
`timescale 1ns / 100ps

module stereo_flanger_unit_tb;

   typedef struct {
      logic signed [15:0] left;
      logic signed [15:0] right;
   } frame_type;

   logic clock;
   logic reset;
   logic csr_we;
   logic [sfu_pkg::CSR_IDX_W-1:0] csr_index;
   logic [sfu_pkg::CSR_DATA_W-1:0] csr_wdata;

   sfu_req_if req_bus ();
   sfu_rsp_if rsp_bus ();

   stereo_flanger_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_bus),
      .rsp_if    (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // shadow of the block state
   int left_line [sfu_pkg::LINE_DEPTH];
   int right_line [sfu_pkg::LINE_DEPTH];
   int wr_ptr;
   int slew_delay;
   int frame_count;
   int lfo_pos;
   int dry_g, wet_g, fb_g, base_d, resp, rate, depth, shape;

   frame_type expected_frames[$];
   int mismatches;
   int send_idle_pct;
   int rsp_idle_pct;
   int hold_left;

   // clock
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // run limit
   initial begin
      #24000000;
      $display("Simulation FAILED");
      $finish;
   end

   // mirror of the block's reset state
   task automatic shadow_reset();
      for (int i = 0; i < sfu_pkg::LINE_DEPTH; i++) begin
         left_line[i] = 0;
         right_line[i] = 0;
      end
      wr_ptr = 0;
      frame_count = 0;
      lfo_pos = 0;
      dry_g = 256;
      wet_g = 128;
      fb_g = 128;
      base_d = 200;
      resp = 2;
      rate = 8;
      depth = 32;
      shape = 0;
      slew_delay = base_d << sfu_pkg::SD_FRAC;
   endtask

   function automatic int clamp16(int v);
      if (v > 32767) begin
         return 32767;
      end
      if (v < -32768) begin
         return -32768;
      end
      return v;
   endfunction

   // predict the frame for one accepted audio request, or apply a phase request
   task automatic flanger_predict(logic kind, int xl, int xr, int phase);
      int p, vib, target, pos, tap_dist, frac, t0, t1, step;
      int tap, y, wb, x;
      frame_type f;
      if (kind == sfu_pkg::REQ_PHASE) begin
         lfo_pos = (phase * 16) & 4095;
         return;
      end
      p = (lfo_pos >> 3) & 511;
      if (shape == 0) begin
         vib = int'(sfu_pkg::HALF_SINE[(p >> 1) & 255]) * 2 - 256;
      end else if (p < 256) begin
         vib = int'(sfu_pkg::HALF_SINE[p]);
      end else begin
         vib = -int'(sfu_pkg::HALF_SINE[p & 255]);
      end
      vib = (vib * depth) / 256;
      target = base_d;
      if (target - depth < 8) begin
         target = 8 + depth;
      end
      if (target + depth > 1000) begin
         target = 1000 - depth;
      end
      target += vib;
      if (target < 0) begin
         target = 0;
      end

      // interpolation taps
      pos = (slew_delay >>> (sfu_pkg::SD_FRAC - 5)) * sfu_pkg::LINE_DEPTH;
      tap_dist = pos / 32768;
      frac = pos & 32767;
      t0 = wr_ptr - tap_dist;
      if (t0 < 0) begin
         t0 += sfu_pkg::LINE_DEPTH;
      end
      t1 = wr_ptr - tap_dist - 1;
      if (t1 < 0) begin
         t1 += sfu_pkg::LINE_DEPTH;
      end
      if (t0 < 0 || t0 >= sfu_pkg::LINE_DEPTH) begin
         t0 = 0;
      end
      if (t1 < 0 || t1 >= sfu_pkg::LINE_DEPTH) begin
         t1 = 0;
      end

      for (int ch = 0; ch < 2; ch++) begin
         x = ch ? xr : xl;
         if (ch == 0) begin
            tap = (left_line[t0] * (32768 - frac) + left_line[t1] * frac) / 32768;
         end else begin
            tap = (right_line[t0] * (32768 - frac) + right_line[t1] * frac) / 32768;
         end
         y = (tap * wet_g) / 256 + (x * dry_g) / 256;
         wb = clamp16(x + (tap * fb_g) / 256);
         if (ch == 0) begin
            left_line[wr_ptr] = wb;
            f.left = 16'(clamp16(y));
         end else begin
            right_line[wr_ptr] = wb;
            f.right = 16'(clamp16(y));
         end
      end
      expected_frames.push_back(f);
      wr_ptr = (wr_ptr + 1 >= sfu_pkg::LINE_DEPTH) ? 0 : wr_ptr + 1;

      // slew toward target
      step = (resp << 2) * sfu_pkg::STEP_UNIT;
      if ((slew_delay >>> sfu_pkg::SD_FRAC) > target) begin
         slew_delay -= step;
         if (slew_delay < 0 || (slew_delay >>> sfu_pkg::SD_FRAC) < target) begin
            slew_delay = target << sfu_pkg::SD_FRAC;
         end
      end else if ((slew_delay >>> sfu_pkg::SD_FRAC) < target) begin
         slew_delay += step;
         if ((slew_delay >>> sfu_pkg::SD_FRAC) > target) begin
            slew_delay = target << sfu_pkg::SD_FRAC;
         end
      end

      // lfo tick
      frame_count++;
      if (frame_count >= sfu_pkg::TICK_PERIOD) begin
         frame_count = 0;
         lfo_pos = (lfo_pos + rate) & 4095;
      end
   endtask

   // send one request, with a random gap before it
   task automatic send_request(logic kind, int xl, int xr, int phase);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.req_type <= kind;
      req_bus.left_in <= 16'(xl);
      req_bus.right_in <= 16'(xr);
      req_bus.phase_value <= 9'(phase);
      do begin
         @(posedge clock);
      end while (!req_bus.ready);
      flanger_predict(kind, xl, xr, phase);
   endtask

   // wait until every expected frame is back and the block is quiet
   task automatic drain();
      int guard;
      req_bus.valid <= 1'b0;
      guard = 0;
      while (expected_frames.size() != 0 && guard < 200000) begin
         @(posedge clock);
         guard++;
      end
      repeat (12) @(posedge clock);
   endtask

   task automatic csr_write(logic [sfu_pkg::CSR_IDX_W-1:0] idx, int value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= sfu_pkg::CSR_DATA_W'(value);
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      case (idx)
         sfu_pkg::REG_DRY:      dry_g = value & 511;
         sfu_pkg::REG_WET:      wet_g = value & 511;
         sfu_pkg::REG_FEEDBACK: fb_g = value & 511;
         sfu_pkg::REG_BASE: begin
            base_d = value & 1023;
            slew_delay = base_d << sfu_pkg::SD_FRAC;
         end
         sfu_pkg::REG_RESPONSE: resp = value & 511;
         sfu_pkg::REG_RATE:     rate = value & 1023;
         sfu_pkg::REG_DEPTH:    depth = value & 511;
         default:               shape = value & 1;
      endcase
   endtask

   task automatic write_all(int d, int w, int fb, int b, int r, int rt, int dp, int sh);
      drain();
      csr_write(sfu_pkg::REG_DRY, d);
      csr_write(sfu_pkg::REG_WET, w);
      csr_write(sfu_pkg::REG_FEEDBACK, fb);
      csr_write(sfu_pkg::REG_BASE, b);
      csr_write(sfu_pkg::REG_RESPONSE, r);
      csr_write(sfu_pkg::REG_RATE, rt);
      csr_write(sfu_pkg::REG_DEPTH, dp);
      csr_write(sfu_pkg::REG_SHAPE, sh);
   endtask

   function automatic int rand_sample();
      case ($urandom_range(5))
         0: return $urandom_range(1) ? 32767 : -32768;
         1: return int'($urandom_range(512)) - 256;
         default: return int'(16'($urandom)) - 32768;
      endcase
   endfunction

   task automatic send_random();
      if ($urandom_range(99) < 8) begin
         send_request(sfu_pkg::REQ_PHASE, rand_sample(), rand_sample(), $urandom_range(511));
      end else begin
         send_request(sfu_pkg::REQ_AUDIO, rand_sample(), rand_sample(), $urandom_range(511));
      end
   endtask

   // result checker
   initial begin
      frame_type f;
      mismatches = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready) begin
            if (expected_frames.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("unexpected frame: left %0d right %0d",
                           rsp_bus.left_out, rsp_bus.right_out);
               end
            end else begin
               f = expected_frames.pop_front();
               if (f.left !== rsp_bus.left_out || f.right !== rsp_bus.right_out) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("frame mismatch: expected %0d/%0d got %0d/%0d",
                              f.left, f.right, rsp_bus.left_out, rsp_bus.right_out);
                  end
               end
            end
         end
      end
   end

   // receiver readiness, with long holds on request
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= rsp_idle_pct);
         end
      end
   end

   // extreme samples and phase requests at default settings
   task automatic test_directed_edges();
      int vals [4] = '{32767, -32768, 0, -1};
      foreach (vals[i]) begin
         send_request(sfu_pkg::REQ_AUDIO, vals[i], vals[3 - i], 0);
      end
      send_request(sfu_pkg::REQ_PHASE, 0, 0, 256);
      send_request(sfu_pkg::REQ_AUDIO, 32767, 32767, 0);
      send_request(sfu_pkg::REQ_PHASE, 0, 0, 511);
      send_request(sfu_pkg::REQ_AUDIO, -32768, -32768, 0);
      send_request(sfu_pkg::REQ_PHASE, 0, 0, 0);
      for (int i = 0; i < 8; i++) begin
         send_request(sfu_pkg::REQ_AUDIO, (i & 1) ? 32767 : -32768,
                      (i & 2) ? 32767 : -32768, 0);
      end
   endtask

   // register extremes, including values above range
   task automatic test_register_sweep();
      write_all(0, 256, 256, 8, 0, 0, 0, 0);
      repeat (30) send_random();
      write_all(256, 256, 256, 1000, 256, 512, 256, 1);
      repeat (30) send_random();
      write_all(511, 511, 511, 1023, 511, 1023, 511, 0);
      repeat (30) send_random();
      write_all(300, 0, 511, 0, 1, 1023, 300, 1);
      repeat (30) send_random();
      write_all(256, 128, 200, 500, 4, 200, 100, 0);
      repeat (30) send_random();
   endtask

   // random traffic under one idling mode, with settings changed midway
   task automatic test_random_traffic(int n, int s_idle, int r_idle);
      send_idle_pct = s_idle;
      rsp_idle_pct = r_idle;
      for (int i = 0; i < n; i++) begin
         if (i == n / 2) begin
            write_all($urandom_range(256), $urandom_range(256), $urandom_range(256),
                      $urandom_range(1000, 8), $urandom_range(256), $urandom_range(512),
                      $urandom_range(256), $urandom_range(1));
         end
         send_random();
      end
   endtask

   // receiver stalls long while requests keep coming
   task automatic test_backpressure();
      send_idle_pct = 0;
      rsp_idle_pct = 0;
      hold_left = 3000;
      repeat (40) send_random();
   endtask

   initial begin
      int guard;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_bus.valid = 1'b0;
      req_bus.req_type = sfu_pkg::REQ_AUDIO;
      req_bus.left_in = '0;
      req_bus.right_in = '0;
      req_bus.phase_value = '0;
      hold_left = 0;
      send_idle_pct = 11;
      rsp_idle_pct = 61;
      shadow_reset();
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      test_directed_edges();
      test_register_sweep();
      test_random_traffic(400, 11, 61);
      test_random_traffic(400, 61, 11);
      test_random_traffic(400, 0, 0);
      test_backpressure();

      req_bus.valid <= 1'b0;
      guard = 0;
      while (expected_frames.size() != 0 && guard < 200000) begin
         @(posedge clock);
         guard++;
      end
      repeat (20) @(posedge clock);
      if (mismatches == 0 && expected_frames.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/core/sfu_pkg.sv
rtl/core/sfu_if.sv
rtl/core/sfu_ram.sv
rtl/core/sfu_lane.sv
rtl/core/sfu_ctrl.sv
rtl/core/stereo_flanger_unit.sv
sim/stereo_flanger_unit_tb.sv
